@@ hw/rtl/message_deframer_resync_top_assert.svh @@
// assertion helpers for the deframer
`ifndef MESSAGE_DEFRAMER_RESYNC_TOP_ASSERT_SVH
`define MESSAGE_DEFRAMER_RESYNC_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// antecedent implies consequent in the cycle after
`define MDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

@@ hw/rtl/mdr_pkg.sv @@
`default_nettype none

package mdr_pkg;

	// fixed field widths
	localparam int unsigned CONN_W   = 4;
	localparam int unsigned CONN_IDS = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned IN_W     = 16;
	localparam int unsigned OUT_W    = 80;
	localparam int unsigned USER_W   = 2;

	// valid command code range
	localparam logic [BYTE_W-1:0] CMD_FIRST = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_LAST  = 8'h04;

	// framing position of one connection
	typedef enum logic [2:0] {
		POS_CMD     = 3'd0,
		POS_HDR1    = 3'd1,
		POS_HDR2    = 3'd2,
		POS_LEN_HI  = 3'd3,
		POS_LEN_LO  = 3'd4,
		POS_PAYLOAD = 3'd5
	} hdr_pos_t;

	// per-connection state word kept in memory
	typedef struct packed {
		logic [CNT_W-1:0] discs;
		logic [CNT_W-1:0] msgs;
		logic [LEN_W-1:0] len;
		hdr_pos_t         pos;
	} conn_state_t;

	localparam int unsigned STATE_W = $bits(conn_state_t);

	// marks for one echoed byte
	typedef struct packed {
		logic last;
		logic first;
		logic kept;
	} byte_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/mdr_ram.sv @@
`default_nettype none

module mdr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/mdr_update.sv @@
`default_nettype none

module mdr_update (
	input  mdr_pkg::conn_state_t      cur,
	input  wire logic [7:0]           data_byte,
	output mdr_pkg::conn_state_t      nxt,
	output mdr_pkg::byte_flags_t      flags
);

	import mdr_pkg::*;

	logic             is_cmd;
	logic [LEN_W-1:0] full_len;
	logic [LEN_W-1:0] left_dec;

	assign is_cmd   = (data_byte >= CMD_FIRST) && (data_byte <= CMD_LAST);
	assign full_len = cur.len | {{(LEN_W-BYTE_W){1'b0}}, data_byte};
	assign left_dec = cur.len - {{(LEN_W-1){1'b0}}, 1'b1};

	// one step of the framing state for this byte
	always_comb begin
		nxt         = cur;
		flags.kept  = 1'b1;
		flags.first = 1'b0;
		flags.last  = 1'b0;
		unique case (cur.pos)
			POS_HDR1: begin
				nxt.pos = POS_HDR2;
			end
			POS_HDR2: begin
				nxt.pos = POS_LEN_HI;
			end
			POS_LEN_HI: begin
				nxt.len = {data_byte, {(LEN_W-BYTE_W){1'b0}}};
				nxt.pos = POS_LEN_LO;
			end
			POS_LEN_LO: begin
				nxt.len = full_len;
				if (full_len == '0) begin
					flags.last = 1'b1;
					nxt.msgs   = cur.msgs + 1'b1;
					nxt.pos    = POS_CMD;
				end else begin
					nxt.pos = POS_PAYLOAD;
				end
			end
			POS_PAYLOAD: begin
				nxt.len = left_dec;
				if (left_dec == '0) begin
					flags.last = 1'b1;
					nxt.msgs   = cur.msgs + 1'b1;
					nxt.pos    = POS_CMD;
				end
			end
			// awaiting a command, also any stray position
			default: begin
				if (is_cmd) begin
					flags.first = 1'b1;
					nxt.pos     = POS_HDR1;
				end else begin
					flags.kept = 1'b0;
					nxt.discs  = cur.discs + 1'b1;
					nxt.pos    = POS_CMD;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/message_deframer_resync_top.sv @@
// path: an accepted byte is captured in stage 1, then moves on to the stage 2 output register
// throughput: one byte per cycle while m_tready holds, set by the single state memory read-modify-write
// a same-entry write from the previous byte is forwarded, so no hazard stall is needed
// reset: asynchronous active-low arst_n clears the pipeline and per-entry valid bits
// all connections read as zero state after reset, no clearing pass is needed
`default_nettype none
`include "message_deframer_resync_top_assert.svh"

module message_deframer_resync_top #(
	parameter int unsigned CONNECTIONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata: conn_id[3:0], data_byte[11:4], zero[15:12]
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,
	// m_tdata: out_conn[3:0], out_byte[11:4], ok_messages[43:12],
	//          discarded_bytes[75:44], zero[79:76]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,
	// m_tuser: kept[0], first[1]
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);

	import mdr_pkg::*;

	// only sixteen connection numbers exist, so at most sixteen entries are used
	localparam int unsigned DEPTH = (CONNECTIONS < CONN_IDS) ? CONNECTIONS : CONN_IDS;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [IDX_W-1:0] idx_map [CONN_IDS];

	logic [CONN_W-1:0] in_conn;
	logic [BYTE_W-1:0] in_byte;
	logic              accept;
	logic              adv;

	logic              vld_s1;
	logic [CONN_W-1:0] conn_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic [DEPTH-1:0]  valid_q;
	logic              fwd_vld_q;
	logic [IDX_W-1:0]  fwd_idx_q;
	conn_state_t       fwd_data_q;

	logic [STATE_W-1:0] rd_data;
	conn_state_t        cur_state;
	conn_state_t        nxt_state;
	byte_flags_t        flags;

	logic              vld_s2;
	logic [CONN_W-1:0] conn_s2;
	logic [BYTE_W-1:0] byte_s2;
	byte_flags_t       flags_s2;
	logic [CNT_W-1:0]  msgs_s2;
	logic [CNT_W-1:0]  discs_s2;

	// connection number to memory entry, worked out at elaboration
	for (genvar gi = 0; gi < CONN_IDS; gi++) begin : g_idx
		assign idx_map[gi] = IDX_W'(gi % DEPTH);
	end

	assign in_conn = s_tdata[CONN_W-1:0];
	assign in_byte = s_tdata[CONN_W+BYTE_W-1:CONN_W];

	// handshake: stage 1 moves on when the output register is free or drains
	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	// stage 1: request captured while its state entry is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			conn_s1 <= in_conn;
			byte_s1 <= in_byte;
			idx_s1  <= idx_map[in_conn];
		end
	end

	mdr_ram #(
		.WIDTH (STATE_W),
		.DEPTH (DEPTH)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (adv),
		.wr_addr (idx_s1),
		.wr_data (nxt_state),
		.rd_en   (accept),
		.rd_addr (idx_map[in_conn]),
		.rd_data (rd_data)
	);

	// current state: last write forwarded, unwritten entries read as zero
	always_comb begin
		if (fwd_vld_q && (fwd_idx_q == idx_s1)) begin
			cur_state = fwd_data_q;
		end else if (valid_q[idx_s1]) begin
			cur_state = conn_state_t'(rd_data);
		end else begin
			cur_state = '0;
		end
	end

	mdr_update u_update (
		.cur       (cur_state),
		.data_byte (byte_s1),
		.nxt       (nxt_state),
		.flags     (flags)
	);

	// entry valid bits and the forwarding copy of the latest write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			fwd_vld_q <= 1'b0;
		end else if (adv) begin
			valid_q[idx_s1] <= 1'b1;
			fwd_vld_q       <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= nxt_state;
		end
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || m_tready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			conn_s2  <= conn_s1;
			byte_s2  <= byte_s1;
			flags_s2 <= flags;
			msgs_s2  <= nxt_state.msgs;
			discs_s2 <= nxt_state.discs;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {{(OUT_W-CONN_W-BYTE_W-2*CNT_W){1'b0}}, discs_s2, msgs_s2,
		byte_s2, conn_s2};
	assign m_tuser  = {flags_s2.first, flags_s2.kept};
	assign m_tlast  = flags_s2.last;

	// checks
	`MDR_ASSERT_NOW(a_drop_unmarked, clk, arst_n, m_tvalid && !m_tuser[0], !m_tuser[1] && !m_tlast)
	`MDR_ASSERT_NOW(a_first_not_last, clk, arst_n, m_tvalid && m_tuser[1], !m_tlast)
	`MDR_ASSERT_NEXT(a_adv_shows, clk, arst_n, adv, m_tvalid && (fwd_idx_q == $past(idx_s1)))

endmodule

`default_nettype wire

@@ tb/sv/message_deframer_resync_checker.sv @@
`timescale 1ns / 1ps

module message_deframer_resync_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	input  wire logic                       s_tready,
	// s_tdata: conn_id[3:0], data_byte[11:4], zero[15:12]
	input  wire logic [mdr_pkg::IN_W-1:0]   s_tdata,
	input  wire logic                       m_tvalid,
	input  wire logic                       m_tready,
	// m_tdata: out_conn[3:0], out_byte[11:4], ok_messages[43:12],
	//          discarded_bytes[75:44], zero[79:76]
	input  wire logic [mdr_pkg::OUT_W-1:0]  m_tdata,
	// m_tuser: kept[0], first[1]
	input  wire logic [mdr_pkg::USER_W-1:0] m_tuser,
	input  wire logic                       m_tlast,
	output int                              errors,
	output int                              pending,
	output int                              checked,
	output int                              msgs_done,
	output int                              drops
);

	import mdr_pkg::*;

	// one echoed byte as the block should show it
	typedef struct packed {
		logic [CNT_W-1:0]  discs;
		logic [CNT_W-1:0]  msgs;
		byte_flags_t       flags;
		logic [BYTE_W-1:0] data;
		logic [CONN_W-1:0] conn;
	} echo_t;

	// framing state per connection
	hdr_pos_t         pos_tab   [CONN_IDS];
	logic [LEN_W-1:0] len_tab   [CONN_IDS];
	logic [LEN_W-1:0] left_tab  [CONN_IDS];
	logic [CNT_W-1:0] msgs_tab  [CONN_IDS];
	logic [CNT_W-1:0] discs_tab [CONN_IDS];

	echo_t echo_due[$];

	// advance the framing of one connection by one byte
	function automatic echo_t deframe_byte(input logic [CONN_W-1:0] c,
			input logic [BYTE_W-1:0] b);
		echo_t e;
		int    idx;
		e = '0;
		idx = int'(c) % CONN_IDS;
		e.conn = c;
		e.data = b;
		e.flags.kept = 1'b1;
		case (pos_tab[idx])
			POS_HDR1: pos_tab[idx] = POS_HDR2;
			POS_HDR2: pos_tab[idx] = POS_LEN_HI;
			POS_LEN_HI: begin
				len_tab[idx] = {b, 8'h00};
				pos_tab[idx] = POS_LEN_LO;
			end
			POS_LEN_LO: begin
				len_tab[idx] = len_tab[idx] | {8'h00, b};
				if (len_tab[idx] == '0) begin
					e.flags.last = 1'b1;
					msgs_tab[idx] = msgs_tab[idx] + 1;
					pos_tab[idx] = POS_CMD;
				end else begin
					left_tab[idx] = len_tab[idx];
					pos_tab[idx] = POS_PAYLOAD;
				end
			end
			POS_PAYLOAD: begin
				left_tab[idx] = left_tab[idx] - 16'd1;
				if (left_tab[idx] == '0) begin
					e.flags.last = 1'b1;
					msgs_tab[idx] = msgs_tab[idx] + 1;
					pos_tab[idx] = POS_CMD;
				end
			end
			// awaiting a command, stray positions included
			default: begin
				if (b >= CMD_FIRST && b <= CMD_LAST) begin
					e.flags.first = 1'b1;
					pos_tab[idx] = POS_HDR1;
				end else begin
					e.flags.kept = 1'b0;
					discs_tab[idx] = discs_tab[idx] + 1;
					pos_tab[idx] = POS_CMD;
				end
			end
		endcase
		e.msgs = msgs_tab[idx];
		e.discs = discs_tab[idx];
		return e;
	endfunction

	// predict on every accepted request, compare on every accepted echo
	always @(posedge clk or negedge arst_n) begin : watch
		echo_t exp;
		if (!arst_n) begin
			for (int i = 0; i < CONN_IDS; i++) begin
				pos_tab[i] = POS_CMD;
				len_tab[i] = '0;
				left_tab[i] = '0;
				msgs_tab[i] = '0;
				discs_tab[i] = '0;
			end
			echo_due.delete();
			errors = 0;
			pending = 0;
			checked = 0;
			msgs_done = 0;
			drops = 0;
		end else begin
			if (s_tvalid && s_tready)
				echo_due.push_back(deframe_byte(s_tdata[3:0], s_tdata[11:4]));
			if (m_tvalid && m_tready) begin
				if (echo_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected echo conn=%0d byte=%02h", $realtime,
							m_tdata[3:0], m_tdata[11:4]);
				end else begin
					exp = echo_due.pop_front();
					checked++;
					if (exp.flags.last)
						msgs_done++;
					if (!exp.flags.kept)
						drops++;
					if (m_tdata[3:0] !== exp.conn || m_tdata[11:4] !== exp.data ||
							m_tuser[0] !== exp.flags.kept || m_tuser[1] !== exp.flags.first ||
							m_tlast !== exp.flags.last || m_tdata[43:12] !== exp.msgs ||
							m_tdata[75:44] !== exp.discs) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch exp conn=%0d byte=%02h k/f/l=%b%b%b msgs=%0d discs=%0d",
								$realtime, exp.conn, exp.data, exp.flags.kept, exp.flags.first,
								exp.flags.last, exp.msgs, exp.discs);
							$display("%0t:          got conn=%0d byte=%02h k/f/l=%b%b%b msgs=%0d discs=%0d",
								$realtime, m_tdata[3:0], m_tdata[11:4], m_tuser[0], m_tuser[1],
								m_tlast, m_tdata[43:12], m_tdata[75:44]);
						end
					end
				end
			end
			pending = echo_due.size();
		end
	end

endmodule

@@ tb/sv/message_deframer_resync_top_test.sv @@
`timescale 1ns / 1ps

module message_deframer_resync_top_test;
	import mdr_pkg::*;

	localparam int unsigned RANDOM_BYTES = 1200;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic [USER_W-1:0] m_tuser;
	logic              m_tlast;

	int errors, pending, checked, msgs_done, drops;

	int unsigned bytes_sent = 0;
	int unsigned burst_left = 0;

	// bytes still to send, per connection
	logic [BYTE_W-1:0] tx_backlog [CONN_IDS][$];

	message_deframer_resync_top #(
		.CONNECTIONS(CONN_IDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	message_deframer_resync_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.msgs_done(msgs_done),
		.drops(drops)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout with %0d echoes outstanding", pending);
		$display("FAILED: results differ");
		$finish;
	end

	// receiver readiness follows a rotating pattern, reloaded now and then
	logic [15:0] ready_pat = 16'hffff;
	int unsigned pat_age = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_pat <= 16'hffff;
			pat_age <= 0;
		end else begin
			if (pat_age == 0) begin
				if ($urandom_range(3, 0) == 0)
					ready_pat <= 16'hffff;
				else
					ready_pat <= 16'($urandom_range(65535, 1));
				pat_age <= $urandom_range(96, 16);
			end else begin
				ready_pat <= {ready_pat[14:0], ready_pat[15]};
				pat_age <= pat_age - 1;
			end
			m_tready <= ready_pat[15];
		end
	end

	// one request, sent in bursts with random gaps between them
	task automatic send_byte(input int c, input logic [BYTE_W-1:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(48, 1);
			gap = ($urandom_range(99, 0) < 35) ? 0 : $urandom_range(20, 1);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'h0, b, 4'(c)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// queue a well-formed message, stray bytes or a cut-off header
	task automatic queue_traffic(input int c);
		int unsigned roll, len, n;
		roll = $urandom_range(99, 0);
		if (roll < 85) begin
			if ($urandom_range(29, 0) == 0)
				len = $urandom_range(300, 256);
			else
				len = $urandom_range(12, 0);
			tx_backlog[c].push_back(8'($urandom_range(CMD_LAST, CMD_FIRST)));
			tx_backlog[c].push_back(8'($urandom()));
			tx_backlog[c].push_back(8'($urandom()));
			tx_backlog[c].push_back(len[15:8]);
			tx_backlog[c].push_back(len[7:0]);
			repeat (len)
				tx_backlog[c].push_back(8'($urandom()));
		end else if (roll < 98) begin
			// noise, mostly bytes that cannot start a message
			n = $urandom_range(4, 1);
			repeat (n) begin
				if ($urandom_range(1, 0) == 0)
					tx_backlog[c].push_back(8'($urandom_range(255, 5)));
				else
					tx_backlog[c].push_back(8'($urandom()));
			end
		end else begin
			n = $urandom_range(3, 0);
			tx_backlog[c].push_back(8'($urandom_range(CMD_LAST, CMD_FIRST)));
			repeat (n)
				tx_backlog[c].push_back(8'($urandom()));
		end
	endtask

	initial begin : stimulus
		int c;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// bad command bytes at both ends of the byte range
		send_byte(0, 8'h00);
		send_byte(0, 8'hff);
		// zero-length message ends on its last header byte
		send_byte(0, 8'h01);
		send_byte(0, 8'h00);
		send_byte(0, 8'hff);
		send_byte(0, 8'h00);
		send_byte(0, 8'h00);
		// two connections interleaved
		send_byte(15, 8'h02);
		send_byte(15, 8'hff);
		send_byte(15, 8'h00);
		send_byte(7, 8'h03);
		send_byte(7, 8'h00);
		send_byte(15, 8'h00);
		send_byte(15, 8'h02);
		send_byte(7, 8'h00);
		send_byte(7, 8'h00);
		send_byte(7, 8'h00);
		send_byte(15, 8'hab);
		send_byte(15, 8'hcd);
		// single payload byte
		send_byte(0, 8'h04);
		send_byte(0, 8'h55);
		send_byte(0, 8'haa);
		send_byte(0, 8'h00);
		send_byte(0, 8'h01);
		send_byte(0, 8'h80);

		// random traffic spread over all connections
		while (bytes_sent < RANDOM_BYTES) begin
			c = $urandom_range(CONN_IDS - 1, 0);
			if (tx_backlog[c].size() == 0)
				queue_traffic(c);
			send_byte(c, tx_backlog[c].pop_front());
		end
		s_tvalid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (10) @(posedge clk);

		$display("sent %0d bytes over %0d connections, %0d echoes checked", bytes_sent,
			CONN_IDS, checked);
		$display("%0d messages completed, %0d bytes dropped while resyncing", msgs_done, drops);
		if (errors == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d echoes missing", errors, pending);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
